// File: rtl/sbta_pkg.sv
// Types and constants shared by the shared buffer threshold admission core.
`timescale 1ns / 1ps
package sbta_pkg;

  localparam int unsigned PORT_W  = 3;
  localparam int unsigned QLEN_W  = 17;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned TMO_W   = 24;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned UCNT_W  = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Register reset values
  localparam logic [15:0] RST_BUFFER_SIZE   = 16'd1024;
  localparam logic [15:0] RST_ALPHA_Q8      = 16'd256;
  localparam logic [23:0] RST_QUIET_TMO     = 24'd1000;
  localparam logic [23:0] RST_UNCTRL_TMO    = 24'd10000;
  localparam logic [15:0] RST_DRAIN_LIMIT   = 16'd3;
  localparam logic [15:0] RST_ACCEPT_LIMIT  = 16'd2;

  typedef enum logic [2:0] {
    CFG_BUFFER_SIZE  = 3'd0,
    CFG_ALPHA_Q8     = 3'd1,
    CFG_QUIET_TMO    = 3'd2,
    CFG_UNCTRL_TMO   = 3'd3,
    CFG_DRAIN_LIMIT  = 3'd4,
    CFG_ACCEPT_LIMIT = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_TICK    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_THRESH_DROP = 3'd1,
    ST_OVFL_DROP   = 3'd2,
    ST_DEQUEUED    = 3'd3,
    ST_EMPTY       = 3'd4,
    ST_TICK        = 3'd5
  } status_e;

  typedef struct packed {
    op_e               operation;
    logic [PORT_W-1:0] port;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [QLEN_W-1:0] queue_length;
    logic [QLEN_W-1:0] total_occupancy;
    logic              port_uncontrolled;
    logic [UCNT_W-1:0] uncontrolled_ports;
  } rsp_t;

endpackage

// File: rtl/sbta_stream_if.sv
// Valid/ready channel carrying one request or one result.
`timescale 1ns / 1ps
interface sbta_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/shared_buffer_threshold_admission_core.sv
// Top level of the shared buffer threshold admission core.
`timescale 1ns / 1ps
// Admission control for a shared packet buffer of up to eight ports.
// Requests arrive on in_i (operation and port) and each one gives exactly
// one result on out_o: a status, the addressed port's queue length, the
// total occupancy, whether the port is uncontrolled and how many ports are.
// A request is registered at the input, evaluated and applied to the
// per-port state once the output register is free or being read, and
// its result is held in an output register, from which the receiver
// takes it. One request is taken every cycle while the receiver does not
// stall; the throughput is set by the read-modify-write of the per-port
// registers.
// When the receiver stalls, the result stays in the output register and one
// further request may wait in the input register; the block then holds
// ready low until the result is taken.
// Reset clears all queue lengths, counters, start times and the time base,
// returns every port to controlled and loads the register defaults.
// Configuration writes on cfg_we_i take effect at once; the user must make
// them only while no request is in flight, as the block does not enforce it.
module shared_buffer_threshold_admission_core #(
  parameter int NUM_PORTS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  sbta_pkg::cfg_idx_e          cfg_idx_i,
  input  logic [sbta_pkg::CFG_W-1:0]  cfg_wdata_i,
  sbta_stream_if.sink                 in_i,
  sbta_stream_if.source               out_o
);
  import sbta_pkg::*;

  // Only ports reachable through the port field get state of their own.
  localparam int MaxAddr  = 2 ** PORT_W;
  localparam int NumSlots = (NUM_PORTS < MaxAddr) ? NUM_PORTS : MaxAddr;
  localparam int IdxW     = $clog2(NumSlots);
  localparam int UW       = $clog2(NumSlots + 1);

  // Configuration registers
  logic [15:0]      buffer_size_q, alpha_q8_q, drain_limit_q, accept_limit_q;
  logic [TMO_W-1:0] quiet_tmo_q, unctrl_tmo_q;

  // Per-port and global state
  logic [QLEN_W-1:0] qlen_q       [NumSlots];
  logic [CNT_W-1:0]  drain_q      [NumSlots];
  logic [CNT_W-1:0]  accept_q     [NumSlots];
  logic [TIME_W-1:0] quiet_st_q   [NumSlots];
  logic [TIME_W-1:0] unctrl_st_q  [NumSlots];
  logic [NumSlots-1:0] flag_q;
  logic [QLEN_W-1:0] occ_q;
  logic [TIME_W-1:0] now_q;
  logic [UW-1:0]     unc_total_q;

  // Pipeline registers
  logic  in_vld_q, out_vld_q;
  req_t  in_data_q;
  rsp_t  out_data_q, rsp_d;
  logic  advance;

  assign advance     = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || advance;
  assign out_o.valid = out_vld_q;
  assign out_o.payload = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_size_q  <= RST_BUFFER_SIZE;
      alpha_q8_q     <= RST_ALPHA_Q8;
      quiet_tmo_q    <= RST_QUIET_TMO;
      unctrl_tmo_q   <= RST_UNCTRL_TMO;
      drain_limit_q  <= RST_DRAIN_LIMIT;
      accept_limit_q <= RST_ACCEPT_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BUFFER_SIZE:  buffer_size_q  <= cfg_wdata_i[15:0];
        CFG_ALPHA_Q8:     alpha_q8_q     <= cfg_wdata_i[15:0];
        CFG_QUIET_TMO:    quiet_tmo_q    <= cfg_wdata_i;
        CFG_UNCTRL_TMO:   unctrl_tmo_q   <= cfg_wdata_i;
        CFG_DRAIN_LIMIT:  drain_limit_q  <= cfg_wdata_i[15:0];
        CFG_ACCEPT_LIMIT: accept_limit_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Input register: holds one request until it can be evaluated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_data_q <= in_i.payload;
    end
  end

  // Evaluation of the registered request.
  logic [IdxW-1:0]   idx;
  logic              hit, is_enq, is_deq, port_op, upd, ovfl;
  logic [QLEN_W-1:0] q;
  logic [CNT_W-1:0]  dc, ac, dc_t, ac_t, dc_inc, ac_inc;
  logic              fl, fl_t, quiet_exp, unc_exp, over;
  logic [TIME_W-1:0] qs, us, el_quiet, el_unc;
  logic [UW-1:0]     total_t;

  logic [QLEN_W-1:0] q_n, occ_n;
  logic [CNT_W-1:0]  dc_n, ac_n;
  logic              fl_n;
  logic [TIME_W-1:0] qs_n, us_n;
  logic [UW-1:0]     total_n;
  status_e           status;

  assign idx     = in_data_q.port[IdxW-1:0];
  assign hit     = 32'(in_data_q.port) < 32'(NUM_PORTS);
  assign is_enq  = (in_data_q.operation == OP_ENQUEUE);
  assign is_deq  = (in_data_q.operation == OP_DEQUEUE);
  assign port_op = hit && (is_enq || is_deq);
  assign upd     = advance && port_op;

  assign q  = qlen_q[idx];
  assign dc = drain_q[idx];
  assign ac = accept_q[idx];
  assign fl = flag_q[idx];
  assign qs = quiet_st_q[idx];
  assign us = unctrl_st_q[idx];

  // Timeouts are checked before the request itself is applied. Elapsed
  // times wrap with the 48-bit time base.
  assign el_quiet  = now_q - qs;
  assign el_unc    = now_q - us;
  assign quiet_exp = !fl && (el_quiet >= TIME_W'(quiet_tmo_q));
  assign unc_exp   = fl && (el_unc >= TIME_W'(unctrl_tmo_q));
  assign fl_t      = fl && !unc_exp;
  assign dc_t      = (quiet_exp || unc_exp) ? '0 : dc;
  assign ac_t      = (quiet_exp || unc_exp) ? '0 : ac;
  assign total_t   = (unc_exp && unc_total_q != '0) ? unc_total_q - 1'b1 : unc_total_q;

  assign ac_inc = (ac_t == CNT_MAX) ? ac_t : ac_t + 1'b1;
  assign dc_inc = (dc_t == CNT_MAX) ? dc_t : dc_t + 1'b1;
  assign ovfl   = occ_q > {1'b0, buffer_size_q};

  sbta_threshold #(
    .UW (UW)
  ) u_threshold (
    .queue_len_i    (q),
    .occupancy_i    (occ_q),
    .uncontrolled_i (fl_t),
    .unc_total_i    (total_t),
    .buffer_size_i  (buffer_size_q),
    .alpha_q8_i     (alpha_q8_q),
    .over_o         (over)
  );

  always_comb begin
    fl_n    = fl_t;
    dc_n    = dc_t;
    ac_n    = ac_t;
    qs_n    = (quiet_exp || unc_exp) ? now_q : qs;
    us_n    = us;
    q_n     = q;
    occ_n   = occ_q;
    total_n = unc_total_q;
    status  = ST_TICK;
    case (in_data_q.operation)
      OP_ENQUEUE: begin
        if (!hit) begin
          status = ST_THRESH_DROP;
        end else begin
          total_n = total_t;
          if (ovfl) begin
            // Overflow sends every port back to controlled.
            status  = ST_OVFL_DROP;
            total_n = '0;
            if (fl_t) begin
              fl_n = 1'b0;
              dc_n = '0;
              ac_n = '0;
              qs_n = now_q;
            end
          end else if (over) begin
            status = ST_THRESH_DROP;
            dc_n   = '0;
            ac_n   = '0;
          end else begin
            status = ST_ACCEPTED;
            q_n    = q + 1'b1;
            occ_n  = occ_q + 1'b1;
            dc_n   = '0;
            if (!fl_t) begin
              if (ac_inc >= accept_limit_q) begin
                fl_n    = 1'b1;
                us_n    = now_q;
                qs_n    = now_q;
                ac_n    = '0;
                total_n = total_t + 1'b1;
              end else begin
                ac_n = ac_inc;
              end
            end
          end
        end
      end
      OP_DEQUEUE: begin
        status = ST_EMPTY;
        if (hit) begin
          total_n = total_t;
          if (q != '0) begin
            status = ST_DEQUEUED;
            q_n    = q - 1'b1;
            occ_n  = (occ_q != '0) ? occ_q - 1'b1 : occ_q;
            dc_n   = dc_inc;
            if (fl_t) begin
              if (dc_inc >= drain_limit_q) begin
                fl_n    = 1'b0;
                dc_n    = '0;
                ac_n    = '0;
                qs_n    = now_q;
                total_n = (total_t != '0) ? total_t - 1'b1 : total_t;
              end
            end else if (ac_t != '0) begin
              ac_n = ac_t - 1'b1;
            end
          end
        end
      end
      default: begin
        status = ST_TICK;
      end
    endcase
  end

  always_comb begin
    rsp_d.status             = status;
    rsp_d.queue_length       = port_op ? q_n : '0;
    rsp_d.total_occupancy    = occ_n;
    rsp_d.port_uncontrolled  = port_op && fl_n;
    rsp_d.uncontrolled_ports = UCNT_W'(total_n);
  end

  // State update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        qlen_q[i]      <= '0;
        drain_q[i]     <= '0;
        accept_q[i]    <= '0;
        quiet_st_q[i]  <= '0;
        unctrl_st_q[i] <= '0;
      end
      flag_q      <= '0;
      occ_q       <= '0;
      now_q       <= '0;
      unc_total_q <= '0;
    end else if (advance) begin
      if (!is_enq && !is_deq) begin
        now_q <= now_q + 1'b1;
      end
      if (upd) begin
        occ_q       <= occ_n;
        unc_total_q <= total_n;
      end
      for (int i = 0; i < NumSlots; i++) begin
        if (upd && IdxW'(i) == idx) begin
          qlen_q[i]      <= q_n;
          drain_q[i]     <= dc_n;
          accept_q[i]    <= ac_n;
          flag_q[i]      <= fl_n;
          quiet_st_q[i]  <= qs_n;
          unctrl_st_q[i] <= us_n;
        end else if (upd && is_enq && ovfl && flag_q[i]) begin
          flag_q[i]     <= 1'b0;
          drain_q[i]    <= '0;
          accept_q[i]   <= '0;
          quiet_st_q[i] <= now_q;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= rsp_d;
    end
  end

  // The running count of uncontrolled ports always matches the flags.
  a_unc_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(unc_total_q) == $countones(flag_q))
    else $error("uncontrolled port count out of step with port flags");

  // An overflow drop leaves no port uncontrolled.
  a_ovfl_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && status == ST_OVFL_DROP) |=> (flag_q == '0))
    else $error("port still uncontrolled after overflow drop");

  // A tick advances the time base by exactly one.
  a_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !is_enq && !is_deq) |=> (now_q == $past(now_q) + 1'b1))
    else $error("time base did not advance on tick");

endmodule

// File: rtl/sbta_threshold.sv
// Dynamic threshold test for one port, controlled or uncontrolled.
`timescale 1ns / 1ps
module sbta_threshold #(
  parameter int unsigned UW = 4
) (
  input  logic [sbta_pkg::QLEN_W-1:0] queue_len_i,
  input  logic [sbta_pkg::QLEN_W-1:0] occupancy_i,
  input  logic                        uncontrolled_i,
  input  logic [UW-1:0]               unc_total_i,
  input  logic [15:0]                 buffer_size_i,
  input  logic [15:0]                 alpha_q8_i,
  output logic                        over_o
);
  import sbta_pkg::*;

  localparam int unsigned UPW = QLEN_W + UW;

  logic [15:0]     room;
  logic [31:0]     limit;
  logic [31:0]     scaled_len;
  logic [UPW-1:0]  share;

  // Room left in the buffer; none once occupancy reaches the capacity.
  assign room       = (occupancy_i < {1'b0, buffer_size_i}) ?
                      (buffer_size_i - occupancy_i[15:0]) : 16'd0;
  assign limit      = alpha_q8_i * room;
  assign scaled_len = {7'd0, queue_len_i, 8'd0};
  assign share      = UPW'(queue_len_i) * UPW'(unc_total_i);

  always_comb begin
    if (uncontrolled_i) begin
      over_o = (unc_total_i != '0) && (share > UPW'(buffer_size_i));
    end else begin
      over_o = scaled_len > limit;
    end
  end

endmodule
